### rtl/arot_pkg.sv
// arot_pkg: shared constants for the axis-angle rotation matrix block.
// Holds the CORDIC gain, datapath width and the arctangent table.
// No dependencies.
package arot_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 32;

    // CORDIC datapath: Q2.30 plus guard bits
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES_MAX] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

endpackage

### rtl/arot_cordic_cell.sv
// arot_cordic_cell: one rotation-mode CORDIC micro-rotation with its register.
// Carries the axis components alongside. Depends on arot_pkg.
module arot_cordic_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STAGE        = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic signed [arot_pkg::CW-1:0]        x_in,
    input  logic signed [arot_pkg::CW-1:0]        y_in,
    input  logic signed [arot_pkg::CW-1:0]        z_in,
    input  logic signed [SAMPLE_WIDTH-1:0]        ax_in,
    input  logic signed [SAMPLE_WIDTH-1:0]        ay_in,
    input  logic signed [SAMPLE_WIDTH-1:0]        az_in,
    output logic                                  vld_out,
    output logic signed [arot_pkg::CW-1:0]        x_out,
    output logic signed [arot_pkg::CW-1:0]        y_out,
    output logic signed [arot_pkg::CW-1:0]        z_out,
    output logic signed [SAMPLE_WIDTH-1:0]        ax_out,
    output logic signed [SAMPLE_WIDTH-1:0]        ay_out,
    output logic signed [SAMPLE_WIDTH-1:0]        az_out
);
    import arot_pkg::*;

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_TURNS[STAGE]);

    logic                   vld_reg;
    logic signed [CW-1:0]   x_reg, y_reg, z_reg;
    logic signed [CW-1:0]   x_next, y_next, z_next;
    logic signed [CW-1:0]   xs, ys;
    logic signed [SAMPLE_WIDTH-1:0] ax_reg, ay_reg, az_reg;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!z_in[CW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            ax_reg <= ax_in;
            ay_reg <= ay_in;
            az_reg <= az_in;
        end
    end

    assign vld_out = vld_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign ax_out  = ax_reg;
    assign ay_out  = ay_reg;
    assign az_out  = az_reg;

endmodule

### rtl/arot_rodrigues.sv
// arot_rodrigues: turns CORDIC x/y and the axis into the nine matrix elements.
// Three register stages: sin/cos and axis products, scaled terms, sums.
// Depends on arot_pkg.
module arot_rodrigues #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             vld_in,
    input  logic signed [arot_pkg::CW-1:0]   x_in,
    input  logic signed [arot_pkg::CW-1:0]   y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]   ax_in,
    input  logic signed [SAMPLE_WIDTH-1:0]   ay_in,
    input  logic signed [SAMPLE_WIDTH-1:0]   az_in,
    output logic                             vld_out,
    output logic signed [SAMPLE_WIDTH-1:0]   r00,
    output logic signed [SAMPLE_WIDTH-1:0]   r10,
    output logic signed [SAMPLE_WIDTH-1:0]   r20,
    output logic signed [SAMPLE_WIDTH-1:0]   r01,
    output logic signed [SAMPLE_WIDTH-1:0]   r11,
    output logic signed [SAMPLE_WIDTH-1:0]   r21,
    output logic signed [SAMPLE_WIDTH-1:0]   r02,
    output logic signed [SAMPLE_WIDTH-1:0]   r12,
    output logic signed [SAMPLE_WIDTH-1:0]   r22
);
    import arot_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int F  = W - 2;
    localparam int RS = 30 - F;      // Q2.30 down to Q1.F
    localparam int PW = 2 * W + 2;   // product width
    localparam int TW = W + 3;       // scaled term width
    localparam int SW = W + 4;       // sum width

    localparam logic signed [CW-1:0] ONE_C  = CW'(1) <<< F;
    localparam logic signed [W:0]    ONE_W  = (W + 1)'(1) <<< F;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (F - 1);
    localparam logic signed [TW-1:0] LIM    = (TW'(1) <<< (F + 2)) - TW'(1);
    localparam logic signed [SW-1:0] MAXV   = {{5{1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] MINV   = ~MAXV;

    // product of two Q.F values, rounded to F fraction bits
    function automatic logic signed [TW-1:0] mul_rnd(input logic signed [W:0] a,
                                                     input logic signed [W:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        p = (p + HALF_P) >>> F;
        return TW'(p);
    endfunction

    function automatic logic signed [W:0] sq_clamp(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [TW-1:0] p;
        p = mul_rnd((W + 1)'(a), (W + 1)'(b));
        if (p > LIM)
            p = LIM;
        else if (p < -LIM)
            p = -LIM;
        return (W + 1)'(p);
    endfunction

    function automatic logic signed [CW-1:0] trig_clamp(input logic signed [CW-1:0] v);
        if (v > ONE_C)
            return ONE_C;
        else if (v < -ONE_C)
            return -ONE_C;
        return v;
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        if (v > MAXV)
            return MAXV[W-1:0];
        else if (v < MINV)
            return MINV[W-1:0];
        return v[W-1:0];
    endfunction

    // ---- stage 1: cos/sin, 1-cos, axis products
    logic signed [CW-1:0] x_rnd, y_rnd;

    generate
        if (RS == 0)
        begin : g_nornd
            assign x_rnd = x_in;
            assign y_rnd = y_in;
        end
        else
        begin : g_rnd
            assign x_rnd = (x_in + (CW'(1) <<< (RS - 1))) >>> RS;
            assign y_rnd = (y_in + (CW'(1) <<< (RS - 1))) >>> RS;
        end
    endgenerate

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [W-1:0]   c1_cos_reg, c1_sin_reg;
    logic signed [W:0]     omc_reg;
    logic signed [W:0]     xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [W-1:0]   ax1_reg, ay1_reg, az1_reg;
    logic signed [CW-1:0]  cos_cl, sin_cl;

    assign cos_cl = trig_clamp(x_rnd);
    assign sin_cl = trig_clamp(y_rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_cos_reg <= cos_cl[W-1:0];
            c1_sin_reg <= sin_cl[W-1:0];
            omc_reg    <= ONE_W - (W + 1)'(cos_cl);
            xx_reg     <= sq_clamp(ax_in, ax_in);
            yy_reg     <= sq_clamp(ay_in, ay_in);
            zz_reg     <= sq_clamp(az_in, az_in);
            xy_reg     <= sq_clamp(ax_in, ay_in);
            xz_reg     <= sq_clamp(ax_in, az_in);
            yz_reg     <= sq_clamp(ay_in, az_in);
            ax1_reg    <= ax_in;
            ay1_reg    <= ay_in;
            az1_reg    <= az_in;
        end
    end

    // ---- stage 2: scaled terms
    logic signed [TW-1:0] txx_reg, tyy_reg, tzz_reg, txy_reg, txz_reg, tyz_reg;
    logic signed [TW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [W-1:0]  cos2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            txx_reg  <= mul_rnd(omc_reg, xx_reg);
            tyy_reg  <= mul_rnd(omc_reg, yy_reg);
            tzz_reg  <= mul_rnd(omc_reg, zz_reg);
            txy_reg  <= mul_rnd(omc_reg, xy_reg);
            txz_reg  <= mul_rnd(omc_reg, xz_reg);
            tyz_reg  <= mul_rnd(omc_reg, yz_reg);
            sx_reg   <= mul_rnd((W + 1)'(c1_sin_reg), (W + 1)'(ax1_reg));
            sy_reg   <= mul_rnd((W + 1)'(c1_sin_reg), (W + 1)'(ay1_reg));
            sz_reg   <= mul_rnd((W + 1)'(c1_sin_reg), (W + 1)'(az1_reg));
            cos2_reg <= c1_cos_reg;
        end
    end

    // ---- stage 3: sums and saturation into the output register
    logic signed [SW-1:0] cos_s;
    logic signed [W-1:0]  r00_reg, r10_reg, r20_reg, r01_reg, r11_reg;
    logic signed [W-1:0]  r21_reg, r02_reg, r12_reg, r22_reg;

    assign cos_s = SW'(cos2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r00_reg <= sat(SW'(txx_reg) + cos_s);
            r10_reg <= sat(SW'(txy_reg) + SW'(sz_reg));
            r20_reg <= sat(SW'(txz_reg) - SW'(sy_reg));
            r01_reg <= sat(SW'(txy_reg) - SW'(sz_reg));
            r11_reg <= sat(SW'(tyy_reg) + cos_s);
            r21_reg <= sat(SW'(tyz_reg) + SW'(sx_reg));
            r02_reg <= sat(SW'(txz_reg) + SW'(sy_reg));
            r12_reg <= sat(SW'(tyz_reg) - SW'(sx_reg));
            r22_reg <= sat(SW'(tzz_reg) + cos_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign vld_out = v3_reg;
    assign r00 = r00_reg;
    assign r10 = r10_reg;
    assign r20 = r20_reg;
    assign r01 = r01_reg;
    assign r11 = r11_reg;
    assign r21 = r21_reg;
    assign r02 = r02_reg;
    assign r12 = r12_reg;
    assign r22 = r22_reg;

endmodule

### rtl/axis_angle_rotation_matrix.sv
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   axis_x axis_y axis_z turn_angle
// out       out  out_valid / out_stall r00 r10 r20 r01 r11 r21 r02 r12 r22
//
// One item per cycle unless the output is stalled; registers in order: angle fold
// register, one per CORDIC cell, three Rodrigues stages whose last is the output.
// Reset clears only the valid bits; no clearing pass.
// A stalled output holds the whole pipeline; in_stall follows out_stall while
// an item waits in the output register.
//
// Top level: axis-angle to 3x3 rotation matrix. Uses arot_pkg,
// arot_cordic_cell and arot_rodrigues.
module axis_angle_rotation_matrix #(
    parameter int SAMPLE_WIDTH  = arot_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = arot_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] axis_x,
    input  logic signed [SAMPLE_WIDTH-1:0] axis_y,
    input  logic signed [SAMPLE_WIDTH-1:0] axis_z,
    input  logic signed [SAMPLE_WIDTH-1:0] turn_angle,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] r00,
    output logic signed [SAMPLE_WIDTH-1:0] r10,
    output logic signed [SAMPLE_WIDTH-1:0] r20,
    output logic signed [SAMPLE_WIDTH-1:0] r01,
    output logic signed [SAMPLE_WIDTH-1:0] r11,
    output logic signed [SAMPLE_WIDTH-1:0] r21,
    output logic signed [SAMPLE_WIDTH-1:0] r02,
    output logic signed [SAMPLE_WIDTH-1:0] r12,
    output logic signed [SAMPLE_WIDTH-1:0] r22
);
    import arot_pkg::*;

    localparam int W = SAMPLE_WIDTH;
    localparam int N = CORDIC_STAGES;

    logic en;
    logic vld_out;

    assign en       = !(vld_out && out_stall);
    assign in_stall = !en;

    // angle as a 32-bit turn count; fold the outer half-circle by pi
    logic [31:0]          ang32;
    logic                 fold;
    logic signed [CW-1:0] z_fold, x_start;

    assign ang32   = 32'({1'b0, turn_angle} & {1'b0, {W{1'b1}}}) << (32 - W);
    assign fold    = ang32[31] ^ ang32[30];
    assign z_fold  = CW'(signed'({ang32[31] ^ fold, ang32[30:0]}));
    assign x_start = fold ? -CORDIC_GAIN : CORDIC_GAIN;

    logic                  vc     [0:N];
    logic signed [CW-1:0]  xc     [0:N];
    logic signed [CW-1:0]  yc     [0:N];
    logic signed [CW-1:0]  zc     [0:N];
    logic signed [W-1:0]   axc    [0:N];
    logic signed [W-1:0]   ayc    [0:N];
    logic signed [W-1:0]   azc    [0:N];

    logic                  v0_reg;
    logic signed [CW-1:0]  x0_reg, z0_reg;
    logic signed [W-1:0]   ax0_reg, ay0_reg, az0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= x_start;
            z0_reg  <= z_fold;
            ax0_reg <= axis_x;
            ay0_reg <= axis_y;
            az0_reg <= axis_z;
        end
    end

    assign vc[0]  = v0_reg;
    assign xc[0]  = x0_reg;
    assign yc[0]  = '0;
    assign zc[0]  = z0_reg;
    assign axc[0] = ax0_reg;
    assign ayc[0] = ay0_reg;
    assign azc[0] = az0_reg;

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            arot_cordic_cell #(
                .SAMPLE_WIDTH (W),
                .STAGE        (i)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .vld_in  (vc[i]),
                .x_in    (xc[i]),
                .y_in    (yc[i]),
                .z_in    (zc[i]),
                .ax_in   (axc[i]),
                .ay_in   (ayc[i]),
                .az_in   (azc[i]),
                .vld_out (vc[i+1]),
                .x_out   (xc[i+1]),
                .y_out   (yc[i+1]),
                .z_out   (zc[i+1]),
                .ax_out  (axc[i+1]),
                .ay_out  (ayc[i+1]),
                .az_out  (azc[i+1])
            );
        end
    endgenerate

    arot_rodrigues #(
        .SAMPLE_WIDTH (W)
    ) u_rodrigues (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vc[N]),
        .x_in    (xc[N]),
        .y_in    (yc[N]),
        .ax_in   (axc[N]),
        .ay_in   (ayc[N]),
        .az_in   (azc[N]),
        .vld_out (vld_out),
        .r00     (r00),
        .r10     (r10),
        .r20     (r20),
        .r01     (r01),
        .r11     (r11),
        .r21     (r21),
        .r02     (r02),
        .r12     (r12),
        .r22     (r22)
    );

    assign out_valid = vld_out;

endmodule
